/* sv/command_packet_framer_defines.svh */
// assertion macros used by the checker file of the command packet framer
// no dependencies
`ifndef COMMAND_PACKET_FRAMER_DEFINES_SVH
`define COMMAND_PACKET_FRAMER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define CPF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpf assertion failed");

// next-cycle implication, off while reset is high
`define CPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpf assertion failed");

// same-cycle implication that also holds through reset
`define CPF_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("cpf assertion failed");

`endif

/* sv/cpf_pkg.sv */
// package of the command packet framer: frame constants, beat positions, crc step
// no dependencies
package cpf_pkg;

   localparam logic [7:0]  SYNC0_BYTE   = 8'h55;
   localparam logic [7:0]  SYNC1_BYTE   = 8'h66;
   localparam logic [7:0]  CONTROL_BYTE = 8'h01;
   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [15:0] CRC_INIT     = 16'h0000;
   localparam logic [15:0] CRC_MSB      = 16'h8000;

   localparam int unsigned BEAT_W = 4;
   typedef logic [BEAT_W-1:0] beat_type;

   // beat positions within a start item
   localparam beat_type BEAT_HDR_SYNC0   = 4'd0;
   localparam beat_type BEAT_HDR_SYNC1   = 4'd1;
   localparam beat_type BEAT_HDR_CONTROL = 4'd2;
   localparam beat_type BEAT_HDR_LEN_LO  = 4'd3;
   localparam beat_type BEAT_HDR_LEN_HI  = 4'd4;
   localparam beat_type BEAT_HDR_SEQ_LO  = 4'd5;
   localparam beat_type BEAT_HDR_SEQ_HI  = 4'd6;
   localparam beat_type BEAT_HDR_CMD     = 4'd7;
   localparam beat_type BEAT_HDR_CRC_LO  = 4'd8;
   localparam beat_type BEAT_HDR_CRC_HI  = 4'd9;

   // beat positions within a payload item
   localparam beat_type BEAT_PL_DATA   = 4'd0;
   localparam beat_type BEAT_PL_CRC_LO = 4'd1;
   localparam beat_type BEAT_PL_CRC_HI = 4'd2;

   // crc-16, poly 0x1021, msb first, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* sv/command_packet_framer.sv */
// command packet framer top level: header, payload pass-through, crc trailer
// depends on cpf_pkg
// ---------------------------------------------------------------------------
// usage
//   req channel: one beat is one item. start_frame=1 opens a frame (cmd_id,
//   payload_len used), start_frame=0 carries one payload byte (data_byte).
//   rsp channel: one beat is one byte of the framed packet. run_last marks
//   the final beat caused by an item, frame_end the crc high byte, and
//   stray_error a payload byte that arrived with no frame open.
// throughput
//   a taken item is registered as the held item; its beats go out through
//   the rsp register. rsp moves one beat per cycle while not stalled, set
//   by the single serializer stage that walks the beats of the held item:
//   a start gives 8 beats (10 when the payload is empty), a payload byte 1
//   beat (3 on the last byte, which appends the crc), a stray byte 1 beat.
//   the next item is taken in the cycle the current item's last beat moves
//   to the rsp register, so unstalled payload bytes stream at one per cycle.
// reset
//   synchronous, active high: no frame open, crc and sequence number zero,
//   no beat pending on rsp.
// stall
//   a stalled rsp beat holds; the serializer and then req_stall back up
//   behind it. no beat is dropped or repeated.
// ---------------------------------------------------------------------------
module command_packet_framer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_frame,
   input  logic [7:0]  req_cmd_id,
   input  logic [15:0] req_payload_len,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic        rsp_stray_error
);

   // held item
   logic        busy_ff, busy_in;
   cpf_pkg::beat_type idx_ff, idx_in;
   logic        item_start_ff;
   logic [7:0]  item_cmd_ff;
   logic [15:0] item_len_ff;
   logic [7:0]  item_data_ff;

   // frame state
   logic [15:0] crc_ff, crc_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] remaining_ff, remaining_in;
   logic        open_ff, open_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_end_ff, rsp_end_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_err_ff, rsp_err_in;

   // current beat
   logic        advance;
   logic        accept;
   logic [7:0]  beat_byte;
   logic        beat_is_data;   // byte goes into the crc
   logic        beat_end;
   logic        beat_err;
   logic        beat_last;
   logic [15:0] crc_base;
   logic [15:0] crc_next;

   // serializer moves a beat whenever the rsp register is free or draining
   assign advance   = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy_ff && !(advance && beat_last);
   assign accept    = req_valid && !req_stall;

   // a start restarts the crc from the first header byte
   assign crc_base = (item_start_ff && (idx_ff == cpf_pkg::BEAT_HDR_SYNC0)) ?
                     cpf_pkg::CRC_INIT : crc_ff;
   assign crc_next = cpf_pkg::crc_byte(crc_base, beat_byte);

   // beat decode
   always_comb begin
      beat_byte    = 8'h00;
      beat_is_data = 1'b0;
      beat_end     = 1'b0;
      beat_err     = 1'b0;
      beat_last    = 1'b0;
      if (item_start_ff) begin
         case (idx_ff)
            cpf_pkg::BEAT_HDR_SYNC0: begin
               beat_byte    = cpf_pkg::SYNC0_BYTE;
               beat_is_data = 1'b1;
            end
            cpf_pkg::BEAT_HDR_SYNC1: begin
               beat_byte    = cpf_pkg::SYNC1_BYTE;
               beat_is_data = 1'b1;
            end
            cpf_pkg::BEAT_HDR_CONTROL: begin
               beat_byte    = cpf_pkg::CONTROL_BYTE;
               beat_is_data = 1'b1;
            end
            cpf_pkg::BEAT_HDR_LEN_LO: begin
               beat_byte    = item_len_ff[7:0];
               beat_is_data = 1'b1;
            end
            cpf_pkg::BEAT_HDR_LEN_HI: begin
               beat_byte    = item_len_ff[15:8];
               beat_is_data = 1'b1;
            end
            cpf_pkg::BEAT_HDR_SEQ_LO: begin
               beat_byte    = seq_ff[7:0];
               beat_is_data = 1'b1;
            end
            cpf_pkg::BEAT_HDR_SEQ_HI: begin
               beat_byte    = seq_ff[15:8];
               beat_is_data = 1'b1;
            end
            cpf_pkg::BEAT_HDR_CMD: begin
               beat_byte    = item_cmd_ff;
               beat_is_data = 1'b1;
               // empty payload goes straight on to the crc
               beat_last    = (item_len_ff != 16'h0000);
            end
            cpf_pkg::BEAT_HDR_CRC_LO: begin
               beat_byte = crc_ff[7:0];
            end
            cpf_pkg::BEAT_HDR_CRC_HI: begin
               beat_byte = crc_ff[15:8];
               beat_end  = 1'b1;
               beat_last = 1'b1;
            end
            default: begin
               beat_last = 1'b1;
            end
         endcase
      end else begin
         case (idx_ff)
            cpf_pkg::BEAT_PL_DATA: begin
               if (open_ff) begin
                  beat_byte    = item_data_ff;
                  beat_is_data = 1'b1;
                  // last counted byte goes on to the crc
                  beat_last    = (remaining_ff != 16'h0001);
               end else begin
                  // stray byte, no frame open
                  beat_err  = 1'b1;
                  beat_last = 1'b1;
               end
            end
            cpf_pkg::BEAT_PL_CRC_LO: begin
               beat_byte = crc_ff[7:0];
            end
            cpf_pkg::BEAT_PL_CRC_HI: begin
               beat_byte = crc_ff[15:8];
               beat_end  = 1'b1;
               beat_last = 1'b1;
            end
            default: begin
               beat_last = 1'b1;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      seq_in       = seq_ff;
      remaining_in = remaining_ff;
      open_in      = open_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = beat_byte;
         rsp_end_in   = beat_end;
         rsp_last_in  = beat_last;
         rsp_err_in   = beat_err;
         idx_in       = idx_ff + 4'd1;
         if (beat_is_data) begin
            crc_in = crc_next;
         end
         if (item_start_ff && (idx_ff == cpf_pkg::BEAT_HDR_CMD)) begin
            // header done: frame opens, sequence moves on
            seq_in       = seq_ff + 16'd1;
            remaining_in = item_len_ff;
            open_in      = 1'b1;
         end else if (!item_start_ff && beat_is_data) begin
            remaining_in = remaining_ff - 16'd1;
         end
         if (beat_end) begin
            open_in      = 1'b0;
            remaining_in = 16'h0000;
         end
         if (beat_last) begin
            busy_in = 1'b0;
         end
      end

      if (accept) begin
         busy_in = 1'b1;
         idx_in  = cpf_pkg::BEAT_HDR_SYNC0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= cpf_pkg::BEAT_HDR_SYNC0;
         crc_ff       <= cpf_pkg::CRC_INIT;
         seq_ff       <= 16'h0000;
         remaining_ff <= 16'h0000;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         seq_ff       <= seq_in;
         remaining_ff <= remaining_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_start_ff <= req_start_frame;
         item_cmd_ff   <= req_cmd_id;
         item_len_ff   <= req_payload_len;
         item_data_ff  <= req_data_byte;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_frame_end   = rsp_end_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_stray_error = rsp_err_ff;

endmodule

/* sv/cpf_checker.sv */
// port-level checker for the command packet framer, bound to the top level
// depends on command_packet_framer_defines.svh and command_packet_framer
`include "command_packet_framer_defines.svh"

module cpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_frame_end,
   input logic        rsp_run_last,
   input logic        rsp_stray_error
);

   // stalled beat holds
   `CPF_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))

   // error beat is a lone zero beat
   `CPF_ASSERT_IMPLY(a_stray_beat, clock, reset,
      rsp_valid && rsp_stray_error,
      rsp_run_last && !rsp_frame_end && (rsp_out_byte == 8'h00))

   // the crc high byte always ends its item
   `CPF_ASSERT_IMPLY(a_end_last, clock, reset,
      rsp_valid && rsp_frame_end,
      rsp_run_last && !rsp_stray_error)

   // nothing pending and req open in the first cycle out of reset
   `CPF_ASSERT_ALWAYS(a_reset_empty, clock,
      $past(reset) && !reset,
      !rsp_valid && !req_stall)

endmodule

bind command_packet_framer cpf_checker u_cpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_frame_end  (rsp_frame_end),
   .rsp_run_last   (rsp_run_last),
   .rsp_stray_error(rsp_stray_error)
);

/* sim/command_packet_framer_tb.sv */
// testbench of command_packet_framer: directed table then random frames, both sides idling
// depends on cpf_pkg and the command_packet_framer rtl
`timescale 1ns / 1ps

module command_packet_framer_tb;

   // start_frame as an item kind
   typedef enum logic {
      ITEM_PAYLOAD = 1'b0,
      ITEM_START   = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    cmd_id;
      logic [15:0]   payload_len;
      logic [7:0]    data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
      logic       stray_error;
   } framer_beat_type;

   // one directed row; typed rows carry their single beat written out by hand
   typedef struct packed {
      req_item_type    item;
      logic            typed;
      framer_beat_type want;
   } dir_row_type;

   localparam framer_beat_type NO_BEAT    = '0;
   localparam framer_beat_type STRAY_BEAT = '{8'h00, 1'b0, 1'b1, 1'b1};
   localparam framer_beat_type PASS_FF    = '{8'hFF, 1'b0, 1'b1, 1'b0};
   localparam framer_beat_type PASS_00    = '{8'h00, 1'b0, 1'b1, 1'b0};
   localparam framer_beat_type PASS_80    = '{8'h80, 1'b0, 1'b1, 1'b0};

   localparam int DIRECTED_N   = 20;
   localparam int RANDOM_ITEMS = 160;
   localparam int TAIL_CYCLES  = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SHOW_LIMIT   = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_frame = 1'b0;
   logic [7:0]  req_cmd_id = 8'h00;
   logic [15:0] req_payload_len = 16'h0000;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic        rsp_stray_error;

   command_packet_framer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_frame (req_start_frame),
      .req_cmd_id      (req_cmd_id),
      .req_payload_len (req_payload_len),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_run_last    (rsp_run_last),
      .rsp_stray_error (rsp_stray_error)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // framer state as the predictor sees it
   logic [15:0]  crc_acc       = cpf_pkg::CRC_INIT;
   logic [15:0]  seq_num       = 16'h0000;
   logic [15:0]  bytes_left    = 16'h0000;
   logic         frame_is_open = 1'b0;

   framer_beat_type item_beats[$];      // beats predicted for the item just taken
   framer_beat_type expected_bytes[$];  // beats still owed on rsp, oldest first

   int  items_sent     = 0;
   int  mismatch_count = 0;
   int  beat_count     = 0;
   int  cycle_count    = 0;
   bit  tx_quiet       = 1'b0;       // sender runs with no gaps while set
   bit  rx_quiet       = 1'b0;       // receiver never stalls while set

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // crc-16 0x1021, msb first, one bit of the byte at a time
   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ cpf_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void add_beat(input logic [7:0] b, input logic fe, input logic err);
      framer_beat_type nb;
      nb.out_byte    = b;
      nb.frame_end   = fe;
      nb.run_last    = 1'b0;
      nb.stray_error = err;
      item_beats = {item_beats, nb};
   endfunction

   // a frame byte: goes out and into the crc
   function automatic void add_frame_byte(input logic [7:0] b);
      crc_acc = crc16_next(crc_acc, b);
      add_beat(b, 1'b0, 1'b0);
   endfunction

   // crc trailer, low byte first, closes the frame
   function automatic void add_trailer();
      add_beat(crc_acc[7:0], 1'b0, 1'b0);
      add_beat(crc_acc[15:8], 1'b1, 1'b0);
      frame_is_open = 1'b0;
      bytes_left    = 16'h0000;
   endfunction

   function automatic void predict_frame_bytes(input req_item_type it);
      item_beats.delete();
      if (it.kind == ITEM_START) begin
         // a start drops any open frame and restarts the crc
         crc_acc = cpf_pkg::CRC_INIT;
         add_frame_byte(cpf_pkg::SYNC0_BYTE);
         add_frame_byte(cpf_pkg::SYNC1_BYTE);
         add_frame_byte(cpf_pkg::CONTROL_BYTE);
         add_frame_byte(it.payload_len[7:0]);
         add_frame_byte(it.payload_len[15:8]);
         add_frame_byte(seq_num[7:0]);
         add_frame_byte(seq_num[15:8]);
         add_frame_byte(it.cmd_id);
         seq_num       = seq_num + 16'd1;
         bytes_left    = it.payload_len;
         frame_is_open = 1'b1;
         if (it.payload_len == 16'h0000) begin
            add_trailer();
         end
      end else if (!frame_is_open) begin
         // stray byte: error beat, state untouched
         add_beat(8'h00, 1'b0, 1'b1);
      end else begin
         add_frame_byte(it.data_byte);
         bytes_left = bytes_left - 16'd1;
         if (bytes_left == 16'h0000) begin
            add_trailer();
         end
      end
      item_beats[item_beats.size() - 1].run_last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // req side: random gap, hold the beat until taken, then predict
   // ------------------------------------------------------------------------
   task automatic send_item(input req_item_type it, input logic typed,
                            input framer_beat_type want);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_frame <= it.kind;
      req_cmd_id      <= it.cmd_id;
      req_payload_len <= it.payload_len;
      req_data_byte   <= it.data_byte;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_frame_bytes(it);
      // typed rows still run the predictor so its state stays in step
      if (typed) begin
         expected_bytes = {expected_bytes, want};
      end else begin
         expected_bytes = {expected_bytes, item_beats};
      end
   endtask

   // unused fields get random junk so every bit toggles
   task automatic send_random(input item_kind_type kind, input logic [15:0] len);
      req_item_type it;
      it.kind        = kind;
      it.cmd_id      = 8'($urandom_range(0, 255));
      it.payload_len = (kind == ITEM_START) ? len : 16'($urandom);
      it.data_byte   = 8'($urandom_range(0, 255));
      send_item(it, 1'b0, NO_BEAT);
   endtask

   task automatic drain_expected();
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // rsp side: random stall ahead of each beat, quiet stretches between
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned hold;
      forever begin
         hold = rx_quiet ? 0 : $urandom_range(0, 3);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall && !reset));
         if ($urandom_range(0, 39) == 0) begin
            rx_quiet = !rx_quiet;
         end
      end
   end

   // ------------------------------------------------------------------------
   // checker: every taken rsp beat against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      framer_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT) begin
               $display("beat %0d unexpected: byte %h end %b last %b err %b",
                        beat_count, rsp_out_byte, rsp_frame_end, rsp_run_last,
                        rsp_stray_error);
            end
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_frame_end !== want.frame_end ||
                rsp_run_last !== want.run_last || rsp_stray_error !== want.stray_error) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT) begin
                  $display("beat %0d: want %h/%b/%b/%b got %h/%b/%b/%b",
                           beat_count, want.out_byte, want.frame_end, want.run_last,
                           want.stray_error, rsp_out_byte, rsp_frame_end, rsp_run_last,
                           rsp_stray_error);
               end
            end
         end
         beat_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   dir_row_type directed_rows [DIRECTED_N];

   initial begin : stimulus
      int pick;
      int n;
      directed_rows = '{
         // stray bytes right after reset, junk in the unused fields
         '{'{ITEM_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, STRAY_BEAT},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'h00}, 1'b1, STRAY_BEAT},
         // empty payload: header plus crc in one item, extremes of cmd_id
         '{'{ITEM_START,   8'h00, 16'h0000, 8'hFF}, 1'b0, NO_BEAT},
         '{'{ITEM_START,   8'hFF, 16'h0000, 8'h00}, 1'b0, NO_BEAT},
         // empty frame is already closed
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'h5A}, 1'b1, STRAY_BEAT},
         // three byte frame, data extremes passed through
         '{'{ITEM_START,   8'hA5, 16'h0003, 8'hFF}, 1'b0, NO_BEAT},
         '{'{ITEM_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, PASS_FF},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'h00}, 1'b1, PASS_00},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'h5A}, 1'b0, NO_BEAT},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'h33}, 1'b1, STRAY_BEAT},
         // max length, abandoned by the next start
         '{'{ITEM_START,   8'h3C, 16'hFFFF, 8'h00}, 1'b0, NO_BEAT},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'h80}, 1'b1, PASS_80},
         '{'{ITEM_START,   8'h81, 16'h0001, 8'h00}, 1'b0, NO_BEAT},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'hAA}, 1'b0, NO_BEAT},
         '{'{ITEM_START,   8'h7E, 16'h0002, 8'h00}, 1'b0, NO_BEAT},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'h01}, 1'b0, NO_BEAT},
         // start on top of a start
         '{'{ITEM_START,   8'hC3, 16'h8000, 8'h00}, 1'b0, NO_BEAT},
         '{'{ITEM_START,   8'h18, 16'h0001, 8'h00}, 1'b0, NO_BEAT},
         '{'{ITEM_PAYLOAD, 8'h00, 16'h0000, 8'hFE}, 1'b0, NO_BEAT},
         '{'{ITEM_START,   8'h42, 16'h0000, 8'h00}, 1'b0, NO_BEAT}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      // sender holds off until the block has emptied out
      req_valid <= 1'b0;
      drain_expected();

      // random part: mostly well-formed frames, some cut short, some stray noise
      while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            tx_quiet = !tx_quiet;
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // mostly short frames, now and then a longer one
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            send_random(ITEM_START, 16'(n));
            repeat (n) send_random(ITEM_PAYLOAD, 16'h0000);
         end else if (pick < 87) begin
            // broken frame: cut short, length sometimes huge; next start drops it
            n = $urandom_range(2, 9);
            send_random(ITEM_START, ($urandom_range(0, 1) == 1) ? 16'(n) : 16'($urandom));
            repeat ($urandom_range(0, n - 1)) send_random(ITEM_PAYLOAD, 16'h0000);
         end else begin
            // noise: strays, or tail bytes of a frame left open
            repeat ($urandom_range(1, 3)) send_random(ITEM_PAYLOAD, 16'h0000);
         end
         if ($urandom_range(0, 24) == 0) begin
            req_valid <= 1'b0;
            drain_expected();
         end
      end

      req_valid <= 1'b0;
      drain_expected();
      // single serializer stage, the tail wait covers anything stray
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* command_packet_framer.f */
+incdir+sv
sv/cpf_pkg.sv
sv/command_packet_framer.sv
sv/cpf_checker.sv
sim/command_packet_framer_tb.sv
